### src/lfmg_pkg.sv
package lfmg_pkg;

    localparam int unsigned LIMIT_W  = 16;
    localparam int unsigned PERIOD_W = 17;
    localparam int unsigned LED_W    = 16;
    localparam int unsigned THR_W    = 8;
    localparam int unsigned DUTY_W   = 16;
    localparam int unsigned CNT_W    = 32;
    localparam int unsigned MS_W     = 32;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned DUTY_SHIFT = 8;
    localparam int unsigned PROD_W     = THR_W + PERIOD_W;

    localparam logic [LIMIT_W-1:0]  FAILSAFE_LIMIT_RST = 16'd250;
    localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST     = 17'd500;
    localparam logic [LED_W-1:0]    LED_FAST_RST       = 16'd100;
    localparam logic [LED_W-1:0]    LED_SLOW_RST       = 16'd500;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_LIMIT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LED_FAST       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LED_SLOW       = 4'd3;

    // item kinds
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_PACKET = 1'b1;

    typedef struct packed {
        logic             kind;
        logic             packet_ok;
        logic             arm_request;
        logic [THR_W-1:0] throttle;
    } t_in_item;

    typedef struct packed {
        logic              link_up;
        logic              motors_on;
        logic [DUTY_W-1:0] duty;
        logic              led;
        logic [CNT_W-1:0]  good_packets;
        logic [CNT_W-1:0]  bad_packets;
    } t_out_item;

    typedef struct packed {
        logic [LIMIT_W-1:0]  failsafe_limit_ms;
        logic [PERIOD_W-1:0] pwm_period;
        logic [LED_W-1:0]    led_fast_ms;
        logic [LED_W-1:0]    led_slow_ms;
    } t_cfg;

endpackage

### src/lfmg_cfg.sv
module lfmg_cfg
    import lfmg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                REG_FAILSAFE_LIMIT: n_cfg.failsafe_limit_ms = i_data[LIMIT_W-1:0];
                REG_PWM_PERIOD:     n_cfg.pwm_period        = i_data[PERIOD_W-1:0];
                REG_LED_FAST:       n_cfg.led_fast_ms       = i_data[LED_W-1:0];
                REG_LED_SLOW:       n_cfg.led_slow_ms       = i_data[LED_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.failsafe_limit_ms <= FAILSAFE_LIMIT_RST;
            r_cfg.pwm_period        <= PWM_PERIOD_RST;
            r_cfg.led_fast_ms       <= LED_FAST_RST;
            r_cfg.led_slow_ms       <= LED_SLOW_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/lfmg_core.sv
module lfmg_core
    import lfmg_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    logic [MS_W-1:0]  r_now_ms;
    logic [MS_W-1:0]  r_last_valid_ms;
    logic [MS_W-1:0]  r_last_toggle_ms;
    logic             r_led_level;
    logic [THR_W-1:0] r_held_throttle;
    logic             r_held_arm;
    logic [CNT_W-1:0] r_good_count;
    logic [CNT_W-1:0] r_bad_count;

    logic [MS_W-1:0]  n_now_ms;
    logic [MS_W-1:0]  n_last_valid_ms;
    logic [MS_W-1:0]  n_last_toggle_ms;
    logic             n_led_level;
    logic [THR_W-1:0] n_held_throttle;
    logic             n_held_arm;
    logic [CNT_W-1:0] n_good_count;
    logic [CNT_W-1:0] n_bad_count;

    logic [MS_W-1:0]   since_valid;
    logic [MS_W-1:0]   since_toggle;
    logic              link;
    logic              drive;
    logic [LED_W-1:0]  led_period;
    logic              toggle;
    logic [PROD_W-1:0] product;
    logic [PROD_W-DUTY_SHIFT-1:0] scaled;
    logic [DUTY_W-1:0] duty;

    always_comb begin
        n_now_ms        = r_now_ms;
        n_last_valid_ms = r_last_valid_ms;
        n_held_throttle = r_held_throttle;
        n_held_arm      = r_held_arm;
        n_good_count    = r_good_count;
        n_bad_count     = r_bad_count;
        if (i_item.kind == KIND_TICK) begin
            n_now_ms = r_now_ms + 32'd1;
        end else begin
            n_held_throttle = i_item.throttle;
            n_held_arm      = i_item.arm_request;
            if (i_item.packet_ok) begin
                n_good_count    = r_good_count + 32'd1;
                n_last_valid_ms = r_now_ms;
            end else begin
                n_bad_count = r_bad_count + 32'd1;
            end
        end

        since_valid = n_now_ms - n_last_valid_ms;
        link        = since_valid < {{(MS_W-LIMIT_W){1'b0}}, i_cfg.failsafe_limit_ms};
        drive       = link & n_held_arm;

        // duty scales full throttle 256 to one pwm period, clipped to 16 bits
        product = {{PERIOD_W{1'b0}}, n_held_throttle} * {{THR_W{1'b0}}, i_cfg.pwm_period};
        scaled  = product[PROD_W-1:DUTY_SHIFT];
        if (!drive) begin
            duty = '0;
        end else if (|scaled[PROD_W-DUTY_SHIFT-1:DUTY_W]) begin
            duty = '1;
        end else begin
            duty = scaled[DUTY_W-1:0];
        end

        led_period   = link ? i_cfg.led_fast_ms : i_cfg.led_slow_ms;
        since_toggle = n_now_ms - r_last_toggle_ms;
        toggle       = since_toggle >= {{(MS_W-LED_W){1'b0}}, led_period};
        n_led_level      = r_led_level ^ toggle;
        n_last_toggle_ms = toggle ? n_now_ms : r_last_toggle_ms;

        o_result.link_up      = link;
        o_result.motors_on    = drive;
        o_result.duty         = duty;
        o_result.led          = n_led_level;
        o_result.good_packets = n_good_count;
        o_result.bad_packets  = n_bad_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now_ms         <= '0;
            r_last_valid_ms  <= '0;
            r_last_toggle_ms <= '0;
            r_led_level      <= 1'b0;
            r_held_throttle  <= '0;
            r_held_arm       <= 1'b0;
            r_good_count     <= '0;
            r_bad_count      <= '0;
        end else if (i_go) begin
            r_now_ms         <= n_now_ms;
            r_last_valid_ms  <= n_last_valid_ms;
            r_last_toggle_ms <= n_last_toggle_ms;
            r_led_level      <= n_led_level;
            r_held_throttle  <= n_held_throttle;
            r_held_arm       <= n_held_arm;
            r_good_count     <= n_good_count;
            r_bad_count      <= n_bad_count;
        end
    end

endmodule

### src/link_failsafe_motor_gate.sv
// Radio link failsafe watchdog with motor gate. Each input transaction is a
// one millisecond tick or a received packet; every item yields exactly one
// result with link status, motor enable and duty, LED level and packet counts.
// An item passes an input register, then the combinational update logic (two
// 32-bit time differences and an 8 x 17 multiply) into the result register,
// and one item is accepted every cycle as long as the result side keeps taking
// transactions. Configuration writes are always accepted; indexes beyond the
// four registers are ignored.
module link_failsafe_motor_gate
    import lfmg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_item result;

    logic      r_stage_valid;
    t_in_item  r_stage_item;
    logic      r_out_valid;
    t_out_item r_out;

    logic      out_load;
    logic      stage_load;

    assign o_cfg_ready = 1'b1;

    lfmg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // the staged item moves to the result register once that register frees up
    assign out_load   = r_stage_valid & (~r_out_valid | i_out_ready);
    assign stage_load = i_in_valid & o_in_ready;
    assign o_in_ready = ~r_stage_valid | out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_stage_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_load) begin
            r_stage_item <= i_in;
        end
    end

    lfmg_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (out_load),
        .i_item   (r_stage_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### sim/link_failsafe_motor_gate_tb.sv
module link_failsafe_motor_gate_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lfmg_pkg::*;

    localparam int N_DIR       = 13;
    localparam int N_PHASES    = 10;
    localparam int LONG_HOLD   = 150;
    localparam int TIMEOUT_NS  = 6_000_000;

    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    // reset config: limit 250, period 500, fast 100, slow 500
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{'{KIND_TICK,   1'b0, 1'b0, 8'h00}, 1'b1, '{1'b1, 1'b0, 16'd0,   1'b0, 32'd0, 32'd0}},
        '{'{KIND_PACKET, 1'b0, 1'b1, 8'hFF}, 1'b1, '{1'b1, 1'b1, 16'd498, 1'b0, 32'd0, 32'd1}},
        '{'{KIND_PACKET, 1'b1, 1'b1, 8'h00}, 1'b1, '{1'b1, 1'b1, 16'd0,   1'b0, 32'd1, 32'd1}},
        '{'{KIND_PACKET, 1'b1, 1'b0, 8'hFF}, 1'b1, '{1'b1, 1'b0, 16'd0,   1'b0, 32'd2, 32'd1}},
        '{'{KIND_TICK,   1'b1, 1'b1, 8'hFF}, 1'b1, '{1'b1, 1'b0, 16'd0,   1'b0, 32'd2, 32'd1}},
        '{'{KIND_PACKET, 1'b1, 1'b1, 8'hAA}, 1'b0, '0},
        '{'{KIND_PACKET, 1'b0, 1'b0, 8'h55}, 1'b0, '0},
        '{'{KIND_PACKET, 1'b1, 1'b1, 8'h80}, 1'b0, '0},
        '{'{KIND_TICK,   1'b0, 1'b0, 8'h00}, 1'b0, '0},
        '{'{KIND_PACKET, 1'b0, 1'b1, 8'h01}, 1'b0, '0},
        '{'{KIND_PACKET, 1'b1, 1'b1, 8'hFE}, 1'b0, '0},
        '{'{KIND_TICK,   1'b1, 1'b0, 8'h55}, 1'b0, '0},
        '{'{KIND_PACKET, 1'b1, 1'b1, 8'hFF}, 1'b0, '0}
    };

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_item             o_out;
    logic                  o_cfg_ready;

    // predictor copy of the configuration and the watchdog state
    logic [LIMIT_W-1:0]  cfg_limit;
    logic [PERIOD_W-1:0] cfg_period;
    logic [LED_W-1:0]    cfg_led_fast;
    logic [LED_W-1:0]    cfg_led_slow;
    logic [MS_W-1:0]     ms_now;
    logic [MS_W-1:0]     ms_last_good;
    logic [MS_W-1:0]     ms_last_toggle;
    logic                led_q;
    logic [THR_W-1:0]    thr_held;
    logic                arm_held;
    logic [CNT_W-1:0]    good_cnt;
    logic [CNT_W-1:0]    bad_cnt;

    t_out_item exp_status_q[$];
    int        mismatch_cnt  = 0;
    bit        quiet_tx      = 1'b0;
    bit        quiet_rx      = 1'b0;
    int        holds_asked   = 0;
    int        holds_served  = 0;
    int        rx_stall_left = 0;

    link_failsafe_motor_gate dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void clear_gate_state();
        cfg_limit      = FAILSAFE_LIMIT_RST;
        cfg_period     = PWM_PERIOD_RST;
        cfg_led_fast   = LED_FAST_RST;
        cfg_led_slow   = LED_SLOW_RST;
        ms_now         = '0;
        ms_last_good   = '0;
        ms_last_toggle = '0;
        led_q          = 1'b0;
        thr_held       = '0;
        arm_held       = 1'b0;
        good_cnt       = '0;
        bad_cnt        = '0;
    endfunction

    function automatic t_out_item gate_predict(t_in_item it);
        t_out_item         r;
        logic [PROD_W-1:0] prod;
        logic [LED_W-1:0]  interval;
        logic              link;
        if (it.kind == KIND_TICK) begin
            ms_now = ms_now + 1'b1;
        end else begin
            thr_held = it.throttle;
            arm_held = it.arm_request;
            if (it.packet_ok) begin
                good_cnt     = good_cnt + 1'b1;
                ms_last_good = ms_now;
            end else begin
                bad_cnt = bad_cnt + 1'b1;
            end
        end
        link = (ms_now - ms_last_good) < MS_W'(cfg_limit);
        prod = PROD_W'(thr_held) * PROD_W'(cfg_period);
        r.link_up   = link;
        r.motors_on = link & arm_held;
        if (!r.motors_on) begin
            r.duty = '0;
        end else if ((prod >> DUTY_SHIFT) > PROD_W'({DUTY_W{1'b1}})) begin
            r.duty = '1;
        end else begin
            r.duty = DUTY_W'(prod >> DUTY_SHIFT);
        end
        interval = link ? cfg_led_fast : cfg_led_slow;
        if ((ms_now - ms_last_toggle) >= MS_W'(interval)) begin
            ms_last_toggle = ms_now;
            led_q          = ~led_q;
        end
        r.led          = led_q;
        r.good_packets = good_cnt;
        r.bad_packets  = bad_cnt;
        return r;
    endfunction

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_in_item rand_item(int pkt_pct, int ok_pct);
        t_in_item it;
        it.kind        = (int'($urandom_range(0, 99)) < pkt_pct) ? KIND_PACKET : KIND_TICK;
        it.packet_ok   = int'($urandom_range(0, 99)) < ok_pct;
        it.arm_request = $urandom_range(0, 99) < 85;
        it.throttle    = THR_W'($urandom);
        return it;
    endfunction

    task automatic send_item(t_in_item it, logic typed, t_out_item want);
        int        gap;
        t_out_item predicted;
        gap = quiet_tx ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        predicted = gate_predict(it);
        exp_status_q.push_back(typed ? want : predicted);
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (!o_in_ready);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        while (exp_status_q.size() != 0) @(posedge clk);
        // let the pipeline settle before touching a register
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FAILSAFE_LIMIT: cfg_limit    = data[LIMIT_W-1:0];
            REG_PWM_PERIOD:     cfg_period   = data;
            REG_LED_FAST:       cfg_led_fast = data[LED_W-1:0];
            REG_LED_SLOW:       cfg_led_slow = data[LED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_cfg(logic [CFG_DATA_W-1:0] lim, logic [CFG_DATA_W-1:0] per,
                             logic [CFG_DATA_W-1:0] fast, logic [CFG_DATA_W-1:0] slow);
        write_reg(REG_FAILSAFE_LIMIT, lim);
        write_reg(REG_PWM_PERIOD, per);
        write_reg(REG_LED_FAST, fast);
        write_reg(REG_LED_SLOW, slow);
        // unused index, must leave everything alone
        write_reg(CFG_IDX_W'(REG_LED_SLOW + 1 + $urandom_range(0, 11)), CFG_DATA_W'($urandom));
    endtask

    task automatic check_status(t_out_item got);
        t_out_item want;
        if (exp_status_q.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("status with nothing expected: link %0d duty %0d good %0d bad %0d",
                         got.link_up, got.duty, got.good_packets, got.bad_packets);
            return;
        end
        want = exp_status_q.pop_front();
        if (got.link_up !== want.link_up || got.motors_on !== want.motors_on ||
            got.duty !== want.duty || got.led !== want.led ||
            got.good_packets !== want.good_packets ||
            got.bad_packets !== want.bad_packets) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display({"status mismatch (exp/got): link %0d/%0d motors %0d/%0d ",
                          "duty %0d/%0d led %0d/%0d good %0d/%0d bad %0d/%0d"},
                         want.link_up, got.link_up, want.motors_on, got.motors_on,
                         want.duty, got.duty, want.led, got.led,
                         want.good_packets, got.good_packets,
                         want.bad_packets, got.bad_packets);
        end
    endtask

    // result side: check each transaction, then pick the next ready level
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready)
            check_status(o_out);
        if (holds_served != holds_asked) begin
            holds_served  = holds_asked;
            rx_stall_left = LONG_HOLD;
        end else if (rx_stall_left == 0 && !quiet_rx && $urandom_range(0, 4) == 0) begin
            rx_stall_left = pick_gap();
        end
        if (rx_stall_left > 0) begin
            out_ready <= 1'b0;
            rx_stall_left--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int ph;
        int k;
        int n_items;
        int pkt_pct;
        int ok_pct;
        clear_gate_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < N_DIR; k++)
            send_item(DIR_ROWS[k].stim, DIR_ROWS[k].typed, DIR_ROWS[k].want);

        for (ph = 0; ph < N_PHASES; ph++) begin
            quiet_tx = (ph == 0) || (ph == 3);
            quiet_rx = (ph == 3);
            if (ph == 0) begin
                // receiver holds off while the sender keeps pushing
                holds_asked++;
            end else begin
                in_valid <= 1'b0;
                case (ph)
                    1: apply_cfg(17'd5, 17'd1, 17'd0, 17'd3);
                    2: apply_cfg(17'd0, 17'd0, 17'd1, 17'd1);
                    3: apply_cfg(17'h1FFFF, 17'd65536, 17'd65535, 17'd65535);
                    4: apply_cfg(17'd20, 17'h1FFFF, 17'd7, 17'd13);
                    5: apply_cfg(17'd1, 17'd256, 17'd2, 17'd0);
                    default: apply_cfg({1'($urandom), 16'($urandom_range(1, 60))},
                                       CFG_DATA_W'($urandom),
                                       CFG_DATA_W'($urandom_range(0, 30)),
                                       CFG_DATA_W'($urandom_range(0, 60)));
                endcase
            end
            // long tick runs at the reset limit so the link actually drops
            pkt_pct = (ph == 0) ? 1 : $urandom_range(3, 35);
            ok_pct  = $urandom_range(55, 95);
            n_items = (ph == 0) ? 300 : 160;
            repeat (n_items) send_item(rand_item(pkt_pct, ok_pct), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (exp_status_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
